### hw/rtl/hmac_sha256_engine_defines.svh
// Assertion macros shared by the HMAC-SHA256 engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef HMAC_SHA256_ENGINE_DEFINES_SVH
`define HMAC_SHA256_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HSE_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HSE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### hw/rtl/hse_pkg.sv
// Types, codes and SHA-256 helper functions for the HMAC-SHA256 engine.
// No dependencies.
`default_nettype none

package hse_pkg;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_MSG   = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5c;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] MARK_BYTE = 8'h80;

   localparam int BLOCK_BYTES = 64;
   localparam int LEN_WIDTH   = 61;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] tag_word;
      logic [2:0]  word_index;
      logic        tag_last;
   } rsp_type;

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] hinit(input logic [2:0] i);
      logic [31:0] r;
      unique case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] kround(input logic [5:0] i);
      logic [31:0] r;
      unique case (i)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hmac_sha256_engine.sv
// HMAC-SHA256 engine top level: byte-stream front end, sequencer and one
// shared SHA-256 round unit. Depends on hse_pkg and the defines header.
//
// Usage
// - req channel: one byte item per transfer (kind, data_byte, last).
//   Kind key builds the stored key, kind message feeds the message,
//   kind empty finishes an empty message, kind clear empties the key.
// - rsp channel: eight transfers per finished message, tag words 0..7,
//   big-endian, tag_last on word 7.
// - Byte flow: a stored short-key byte is taken with the sequencer staying
//   idle; a hashed byte is accepted, then loaded into the block buffer;
//   every 64 bytes run 64 rounds of the single round unit plus the
//   chaining add.
// - Tag path: from the last message transfer, the inner padding is
//   compressed; the outer hash then compresses the opad key block and a
//   block of inner digest, padding and length before word 0 appears.
// - req_stall is high whenever the sequencer is busy; one item at a time.
// - A stalled result holds in the output register; the sequencer waits on
//   the next word, and a new item is taken once word 7 is registered.
// - Reset (synchronous) empties the key, returns to idle, drops rsp_valid.
`default_nettype none

`include "hmac_sha256_engine_defines.svh"

module hmac_sha256_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hse_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hse_pkg::rsp_type      rsp_data
);
   import hse_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_KEYLOAD, S_BYTE, S_PAD80, S_PAD0, S_LEN, S_DIG,
      S_ROUND, S_ADD, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_MSG} phase_type;

   // which hash is running: key digest, inner or outer
   typedef enum logic [1:0] {PAD_NONE, PAD_IN, PAD_OUT} pad_type;

   state_type             state_ff, ret_ff, after_st;
   phase_type             phase_ff;
   pad_type               pad_ff;
   logic                  hashing_ff;
   logic [LEN_WIDTH-1:0]  keycnt_ff, len_ff;
   logic [31:0]           key_ff [16];
   logic [31:0]           w_ff [16];
   logic [31:0]           h_ff [8];
   logic [31:0]           v_ff [8];
   logic [31:0]           dig_ff [8];
   logic [5:0]            fill_ff, rnd_ff, sc_ff;
   logic [1:0]            kind_ff;
   logic [7:0]            byte_ff;
   logic                  last_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  feed_en, feed_len;
   logic [7:0]            feed_byte, pad_mask;
   logic [63:0]           len_bits;
   logic [31:0]           t1, t2, w_new;
   logic                  accept, key_phase, short_key;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign key_phase = (phase_ff == PH_KEY);
   // key count below one block, taking a fresh key run as count zero
   assign short_key = !key_phase || (keycnt_ff[LEN_WIDTH-1:6] == '0);
   assign len_bits  = {len_ff, 3'b000};

   always_comb begin
      unique case (pad_ff)
         PAD_IN:  pad_mask = IPAD_BYTE;
         PAD_OUT: pad_mask = OPAD_BYTE;
         default: pad_mask = ZERO_BYTE;
      endcase
   end

   // round unit and message schedule
   always_comb begin
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + kround(rnd_ff) + w_ff[0];
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
           ^ (v_ff[1] & v_ff[2]));
      w_new = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];
   end

   // byte source for the block buffer and the state after the byte
   always_comb begin
      feed_en   = 1'b0;
      feed_len  = 1'b0;
      feed_byte = ZERO_BYTE;
      after_st  = state_ff;
      unique case (state_ff)
         S_KEYLOAD: begin
            feed_en   = 1'b1;
            feed_len  = 1'b1;
            feed_byte = key_ff[sc_ff[5:2]][{~sc_ff[1:0], 3'b000} +: 8] ^ pad_mask;
            if (sc_ff == 6'd63) begin
               priority if (pad_ff == PAD_OUT) after_st = S_DIG;
               else if (pad_ff == PAD_IN && kind_ff != KIND_MSG) after_st = S_PAD80;
               else after_st = S_BYTE;
            end
         end
         S_BYTE: begin
            feed_en   = 1'b1;
            feed_len  = 1'b1;
            feed_byte = byte_ff;
            after_st  = last_ff ? S_PAD80 : S_IDLE;
         end
         S_DIG: begin
            feed_en   = 1'b1;
            feed_len  = 1'b1;
            feed_byte = dig_ff[sc_ff[4:2]][{~sc_ff[1:0], 3'b000} +: 8];
            if (sc_ff == 6'd31) after_st = S_PAD80;
         end
         S_PAD80, S_PAD0: begin
            feed_en   = 1'b1;
            feed_byte = (state_ff == S_PAD80) ? MARK_BYTE : ZERO_BYTE;
            after_st  = (fill_ff == 6'd55) ? S_LEN : S_PAD0;
         end
         S_LEN: begin
            feed_en   = 1'b1;
            feed_byte = len_bits[{~sc_ff[2:0], 3'b000} +: 8];
            if (sc_ff[2:0] == 3'd7) after_st = S_FIN;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         phase_ff     <= PH_IDLE;
         pad_ff       <= PAD_NONE;
         hashing_ff   <= 1'b0;
         keycnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         sc_ff        <= '0;
         rnd_ff       <= '0;
         for (int i = 0; i < 16; i++) key_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         if (feed_en) begin
            w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= feed_byte;
            fill_ff <= fill_ff + 6'd1;
            if (feed_len) len_ff <= len_ff + 1'b1;
            sc_ff <= (after_st == state_ff) ? sc_ff + 6'd1 : 6'd0;
            if (fill_ff == 6'd63) begin
               // block full: compress, then carry on where we were
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               rnd_ff   <= '0;
               ret_ff   <= after_st;
               state_ff <= S_ROUND;
            end else begin
               state_ff <= after_st;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff <= req_data.kind;
                  byte_ff <= req_data.data_byte;
                  last_ff <= req_data.last;
                  unique case (req_data.kind)
                     KIND_KEY: begin
                        if (!key_phase) begin
                           for (int i = 0; i < 16; i++) key_ff[i] <= '0;
                           hashing_ff <= 1'b0;
                        end
                        keycnt_ff <= (key_phase ? keycnt_ff : '0) + 1'b1;
                        phase_ff  <= PH_KEY;
                        priority if (key_phase && hashing_ff) begin
                           pad_ff   <= PAD_NONE;
                           state_ff <= S_BYTE;
                        end else if (short_key) begin
                           key_ff[keycnt_ff[5:2] & {4{key_phase}}]
                              [{~(keycnt_ff[1:0] & {2{key_phase}}), 3'b000} +: 8]
                              <= req_data.data_byte;
                           if (req_data.last) phase_ff <= PH_IDLE;
                        end else begin
                           // key outgrows a block: hash the stored 64 bytes first
                           for (int i = 0; i < 8; i++) h_ff[i] <= hinit(3'(i));
                           fill_ff    <= '0;
                           len_ff     <= '0;
                           sc_ff      <= '0;
                           pad_ff     <= PAD_NONE;
                           hashing_ff <= 1'b1;
                           state_ff   <= S_KEYLOAD;
                        end
                     end
                     KIND_MSG, KIND_EMPTY: begin
                        priority if (key_phase && hashing_ff) begin
                           pad_ff   <= PAD_NONE;
                           state_ff <= S_PAD80;
                        end else if (phase_ff == PH_MSG && req_data.kind == KIND_MSG) begin
                           state_ff <= S_BYTE;
                        end else begin
                           state_ff <= S_START;
                        end
                     end
                     default: begin
                        for (int i = 0; i < 16; i++) key_ff[i] <= '0;
                        keycnt_ff  <= '0;
                        hashing_ff <= 1'b0;
                        phase_ff   <= PH_IDLE;
                     end
                  endcase
               end
            end
            S_START: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= hinit(3'(i));
               fill_ff  <= '0;
               len_ff   <= '0;
               sc_ff    <= '0;
               pad_ff   <= PAD_IN;
               phase_ff <= PH_MSG;
               state_ff <= S_KEYLOAD;
            end
            S_ROUND: begin
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= w_new;
               rnd_ff   <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               state_ff <= ret_ff;
            end
            S_FIN: begin
               unique case (pad_ff)
                  PAD_NONE: begin
                     for (int i = 0; i < 8; i++) begin
                        key_ff[i]   <= h_ff[i];
                        key_ff[i+8] <= '0;
                     end
                     hashing_ff <= 1'b0;
                     phase_ff   <= PH_IDLE;
                     state_ff   <= (kind_ff == KIND_KEY) ? S_IDLE : S_START;
                  end
                  PAD_IN: begin
                     for (int i = 0; i < 8; i++) begin
                        dig_ff[i] <= h_ff[i];
                        h_ff[i]   <= hinit(3'(i));
                     end
                     fill_ff  <= '0;
                     len_ff   <= '0;
                     sc_ff    <= '0;
                     pad_ff   <= PAD_OUT;
                     state_ff <= S_KEYLOAD;
                  end
                  default: begin
                     phase_ff <= PH_IDLE;
                     sc_ff    <= '0;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.tag_word    <= h_ff[sc_ff[2:0]];
                  rsp_ff.word_index  <= sc_ff[2:0];
                  rsp_ff.tag_last    <= (sc_ff[2:0] == 3'd7);
                  sc_ff              <= sc_ff + 6'd1;
                  if (sc_ff[2:0] == 3'd7) state_ff <= S_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   `HSE_ASSERT_NEXT(a_round_end, state_ff == S_ROUND && rnd_ff == 6'd63, state_ff == S_ADD, "round count overran")
   `HSE_ASSERT_NOW(a_fin_aligned, state_ff == S_FIN, fill_ff == 6'd0, "digest taken with partial block")
   `HSE_ASSERT_NOW(a_hash_in_key, hashing_ff, phase_ff == PH_KEY, "key hashing outside key run")
   `HSE_ASSERT_NOW(a_busy_stall, state_ff == S_ROUND, req_stall, "item taken during compression")

endmodule

`default_nettype wire
